>>> rtl/bap_pkg.sv
// ----------------------------------------------------------------------------
// bap_pkg
// Shared types and constants for the beam alignment proportional step block.
// ----------------------------------------------------------------------------
package bap_pkg;

  localparam int NUM_AXES = 4;
  localparam int AXIS_W   = 2;
  localparam int POS_W    = 32;
  localparam int CENT_W   = 24;
  localparam int EXP_W    = 16;
  localparam int STEP_W   = 17;
  localparam int DB_W     = 23;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 31;
  localparam int MSTEP_W  = 16;
  localparam int ORIENT_W = 4;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int IN_TDATA_W  = 168;
  localparam int OUT_TDATA_W = 56;

  localparam logic [DB_W-1:0]     DEAD_BAND_RST    = 23'd7680;
  localparam logic [GAIN_W-1:0]   GAIN_A_RST       = 16'd256;
  localparam logic [GAIN_W-1:0]   GAIN_B_RST       = 16'd256;
  localparam logic [ORIENT_W-1:0] ORIENT_RST       = 4'd0;
  localparam logic [EXP_W-1:0]    MAX_EXPOSURE_RST = 16'd25600;
  localparam logic [LIMIT_W-1:0]  STEP_LIMIT_RST   = 31'd0;
  localparam logic [MSTEP_W-1:0]  MAX_STEP_RST     = 16'd2000;

  typedef enum logic [2:0] {
    STATUS_MOVED     = 3'd0,
    STATUS_ALIGNED   = 3'd1,
    STATUS_EXPOSURE  = 3'd2,
    STATUS_OUT_LIMIT = 3'd3,
    STATUS_REFUSED   = 3'd4,
    STATUS_HOLD      = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    REG_DEAD_BAND    = 3'd0,
    REG_GAIN_A       = 3'd1,
    REG_GAIN_B       = 3'd2,
    REG_ORIENTATION  = 3'd3,
    REG_MAX_EXPOSURE = 3'd4,
    REG_STEP_LIMIT   = 3'd5,
    REG_MAX_STEP     = 3'd6
  } reg_idx_t;

  typedef enum logic {
    OP_FRAME = 1'b0,
    OP_LOAD  = 1'b1
  } opcode_t;

  localparam logic [AXIS_W-1:0] AXIS_A_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_A_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_B_X = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_B_Y = 2'd3;

  typedef struct packed {
    logic [DB_W-1:0]     dead_band;
    logic [GAIN_W-1:0]   gain_a;
    logic [GAIN_W-1:0]   gain_b;
    logic [ORIENT_W-1:0] orientation_mask;
    logic [EXP_W-1:0]    max_exposure;
    logic [LIMIT_W-1:0]  step_limit;
    logic [MSTEP_W-1:0]  max_step;
  } cfg_t;

  typedef struct packed {
    opcode_t                    opcode;
    logic [AXIS_W-1:0]          axis_index;
    logic signed [POS_W-1:0]    position_value;
    logic signed [CENT_W-1:0]   centroid_a_x;
    logic signed [CENT_W-1:0]   centroid_a_y;
    logic signed [CENT_W-1:0]   centroid_b_x;
    logic signed [CENT_W-1:0]   centroid_b_y;
    logic [EXP_W-1:0]           exposure_a;
    logic [EXP_W-1:0]           exposure_b;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic                     move_valid;
    logic [AXIS_W-1:0]        move_axis;
    logic signed [STEP_W-1:0] move_step;
    logic signed [POS_W-1:0]  new_position;
  } result_t;

  typedef struct packed {
    logic                    en;
    logic [AXIS_W-1:0]       axis;
    logic signed [POS_W-1:0] data;
  } pos_wr_t;

endpackage

>>> rtl/bap_regs.sv
// ----------------------------------------------------------------------------
// bap_regs
// Configuration register file with its APB-style access port.
// ----------------------------------------------------------------------------
module bap_regs (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [bap_pkg::ADDR_W-1:0] paddr,
  input  logic [bap_pkg::DATA_W-1:0] pwdata,
  output logic [bap_pkg::DATA_W-1:0] prdata,
  output logic                   pready,
  output bap_pkg::cfg_t          cfg
);
  import bap_pkg::*;

  reg_idx_t idx;
  logic     wr;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dead_band        <= DEAD_BAND_RST;
      cfg.gain_a           <= GAIN_A_RST;
      cfg.gain_b           <= GAIN_B_RST;
      cfg.orientation_mask <= ORIENT_RST;
      cfg.max_exposure     <= MAX_EXPOSURE_RST;
      cfg.step_limit       <= STEP_LIMIT_RST;
      cfg.max_step         <= MAX_STEP_RST;
    end else if (wr) begin
      unique case (idx)
        REG_DEAD_BAND:    cfg.dead_band        <= pwdata[DB_W-1:0];
        REG_GAIN_A:       cfg.gain_a           <= pwdata[GAIN_W-1:0];
        REG_GAIN_B:       cfg.gain_b           <= pwdata[GAIN_W-1:0];
        REG_ORIENTATION:  cfg.orientation_mask <= pwdata[ORIENT_W-1:0];
        REG_MAX_EXPOSURE: cfg.max_exposure     <= pwdata[EXP_W-1:0];
        REG_STEP_LIMIT:   cfg.step_limit       <= pwdata[LIMIT_W-1:0];
        REG_MAX_STEP:     cfg.max_step         <= pwdata[MSTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      REG_DEAD_BAND:    prdata = DATA_W'(cfg.dead_band);
      REG_GAIN_A:       prdata = DATA_W'(cfg.gain_a);
      REG_GAIN_B:       prdata = DATA_W'(cfg.gain_b);
      REG_ORIENTATION:  prdata = DATA_W'(cfg.orientation_mask);
      REG_MAX_EXPOSURE: prdata = DATA_W'(cfg.max_exposure);
      REG_STEP_LIMIT:   prdata = DATA_W'(cfg.step_limit);
      REG_MAX_STEP:     prdata = DATA_W'(cfg.max_step);
      default:          prdata = '0;
    endcase
  end

endmodule

>>> rtl/bap_step_calc.sv
// ----------------------------------------------------------------------------
// bap_step_calc
// Single-pass decision logic: position load, exposure check, axis priority,
// limit checks, clamped proportional step and the result for one input item.
// ----------------------------------------------------------------------------
module bap_step_calc (
  input  bap_pkg::item_t  item,
  input  bap_pkg::cfg_t   cfg,
  input  logic [bap_pkg::NUM_AXES-1:0][bap_pkg::POS_W-1:0] pos,
  output bap_pkg::result_t res,
  output bap_pkg::pos_wr_t pos_wr
);
  import bap_pkg::*;

  logic signed [CENT_W-1:0] err    [NUM_AXES];
  logic [CENT_W-1:0]        errmag [NUM_AXES];
  logic [NUM_AXES-1:0]      over;
  logic [NUM_AXES-1:0]      below;
  logic [NUM_AXES-1:0]      pos_ok;
  logic [CENT_W-1:0]        db_ext;
  logic [CENT_W-1:0]        db2;
  logic [AXIS_W-1:0]        sel;
  logic [CENT_W-1:0]        e_clamp;
  logic [GAIN_W-1:0]        gain;
  logic [CENT_W+GAIN_W-1:0] prod;
  logic [CENT_W-1:0]        m_full;
  logic [MSTEP_W-1:0]       m;
  logic                     neg;
  logic signed [STEP_W-1:0] step;
  logic signed [POS_W:0]    np;
  logic [POS_W:0]           np_mag;
  logic                     np_ok;
  logic                     exp_high;

  assign err[0] = item.centroid_a_x;
  assign err[1] = item.centroid_a_y;
  assign err[2] = item.centroid_b_x;
  assign err[3] = item.centroid_b_y;

  assign db_ext = {1'b0, cfg.dead_band};
  assign db2    = {cfg.dead_band, 1'b0};

  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      logic [POS_W-1:0] pmag;
      errmag[i] = err[i][CENT_W-1] ? (~err[i] + 1'b1) : err[i];
      over[i]   = errmag[i] > db_ext;
      below[i]  = errmag[i] < db_ext;
      pmag      = pos[i][POS_W-1] ? (~pos[i] + 1'b1) : pos[i];
      pos_ok[i] = pmag < {1'b0, cfg.step_limit};
    end
  end

  always_comb begin
    if (over[AXIS_B_X])      sel = AXIS_B_X;
    else if (over[AXIS_B_Y]) sel = AXIS_B_Y;
    else if (over[AXIS_A_Y]) sel = AXIS_A_Y;
    else                     sel = AXIS_A_X;
  end

  // The step sign is opposite to the sign of the oriented error; a zero
  // magnitude gives zero either way.
  assign e_clamp = (errmag[sel] > db2) ? db2 : errmag[sel];
  assign gain    = sel[1] ? cfg.gain_b : cfg.gain_a;
  assign prod    = e_clamp * gain;
  assign m_full  = prod[CENT_W+GAIN_W-1:16];
  assign m       = (m_full > {8'd0, cfg.max_step}) ? cfg.max_step : m_full[MSTEP_W-1:0];
  assign neg     = ~err[sel][CENT_W-1] ^ cfg.orientation_mask[sel];
  assign step    = neg ? -$signed({1'b0, m}) : $signed({1'b0, m});
  assign np      = $signed({pos[sel][POS_W-1], pos[sel]}) + (POS_W+1)'(step);
  assign np_mag  = np[POS_W] ? (~np + 1'b1) : np;
  assign np_ok   = np_mag < {2'b0, cfg.step_limit};

  assign exp_high = (item.exposure_a > cfg.max_exposure) ||
                    (item.exposure_b > cfg.max_exposure);

  always_comb begin
    res    = '0;
    res.status = STATUS_HOLD;
    pos_wr = '0;
    if (item.opcode == OP_LOAD) begin
      res.move_axis    = item.axis_index;
      res.new_position = item.position_value;
      pos_wr.en        = 1'b1;
      pos_wr.axis      = item.axis_index;
      pos_wr.data      = item.position_value;
    end else if (exp_high) begin
      res.status = STATUS_EXPOSURE;
    end else if (!(&pos_ok)) begin
      res.status = STATUS_OUT_LIMIT;
    end else if (over[sel]) begin
      res.move_axis = sel;
      res.move_step = step;
      if (!np_ok) begin
        res.status = STATUS_REFUSED;
      end else begin
        res.status       = STATUS_MOVED;
        res.move_valid   = 1'b1;
        res.new_position = np[POS_W-1:0];
        pos_wr.en        = 1'b1;
        pos_wr.axis      = sel;
        pos_wr.data      = np[POS_W-1:0];
      end
    end else begin
      res.status = (&below) ? STATUS_ALIGNED : STATUS_HOLD;
    end
  end

endmodule

>>> rtl/beam_align_proportional_step.sv
// ----------------------------------------------------------------------------
// beam_align_proportional_step
// Proportional beam alignment controller with deadband for four actuators.
// ----------------------------------------------------------------------------
// The input stream carries one item per frame or position load. s_tuser holds
// the opcode; s_tdata holds the load target, the four centroid errors and the
// two exposures. Every accepted item produces exactly one result item on the
// output stream: m_tuser holds the status, m_tdata the jog command and the
// new actuator position. Registers are written through the APB-style port.
// An accepted item is held in an input register, where the decision logic
// and the 24x16 multiplier evaluate it combinationally; when it advances, the
// result register is loaded and the actuator position table is updated. Each
// result passes through the input and result registers before its output
// handshake; one item per cycle is sustained while m_tready stays high.
// The output register holds a result while m_tready is low; the input register
// still takes one more item, after which s_tready drops until the output moves.
// Reset clears both valid flags, restores register defaults and sets all
// actuator positions to zero.
// ----------------------------------------------------------------------------
module beam_align_proportional_step (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // [1:0] axis_index, [33:2] position_value, [57:34] centroid_a_x,
  // [81:58] centroid_a_y, [105:82] centroid_b_x, [129:106] centroid_b_y,
  // [145:130] exposure_a, [161:146] exposure_b, [167:162] zero.
  input  logic [bap_pkg::IN_TDATA_W-1:0] s_tdata,
  // [0] opcode.
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // [0] move_valid, [2:1] move_axis, [19:3] move_step, [51:20] new_position,
  // [55:52] zero.
  output logic [bap_pkg::OUT_TDATA_W-1:0] m_tdata,
  // [2:0] status.
  output logic [2:0] m_tuser,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [bap_pkg::ADDR_W-1:0] paddr,
  input  logic [bap_pkg::DATA_W-1:0] pwdata,
  output logic [bap_pkg::DATA_W-1:0] prdata,
  output logic pready
);
  import bap_pkg::*;

  cfg_t    cfg;
  item_t   item_in;
  item_t   item;
  logic    item_valid;
  logic    advance;
  result_t res_next;
  result_t res;
  pos_wr_t pos_wr;
  logic [NUM_AXES-1:0][POS_W-1:0] pos;

  bap_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign item_in.opcode         = opcode_t'(s_tuser);
  assign item_in.axis_index     = s_tdata[1:0];
  assign item_in.position_value = s_tdata[33:2];
  assign item_in.centroid_a_x   = s_tdata[57:34];
  assign item_in.centroid_a_y   = s_tdata[81:58];
  assign item_in.centroid_b_x   = s_tdata[105:82];
  assign item_in.centroid_b_y   = s_tdata[129:106];
  assign item_in.exposure_a     = s_tdata[145:130];
  assign item_in.exposure_b     = s_tdata[161:146];

  assign advance  = item_valid && (!m_tvalid || m_tready);
  assign s_tready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tready) begin
      item_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      item <= item_in;
    end
  end

  bap_step_calc u_calc (
    .item   (item),
    .cfg    (cfg),
    .pos    (pos),
    .res    (res_next),
    .pos_wr (pos_wr)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (advance && pos_wr.en) begin
      pos[pos_wr.axis] <= pos_wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign m_tuser = res.status;
  assign m_tdata = {4'd0, res.new_position, res.move_step, res.move_axis, res.move_valid};

endmodule
